FILE: rtl/sorted_linked_list_table_macros.svh
// ----------------------------------------------------------------------------
// sorted_linked_list_table_macros
// assertion macros for the sorted linked list table
// ----------------------------------------------------------------------------
`ifndef SORTED_LINKED_LIST_TABLE_MACROS_SVH
`define SORTED_LINKED_LIST_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SLLT_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sllt assertion failed");

// next-cycle implication
`define SLLT_ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sllt assertion failed");

`else

`define SLLT_ASSERT_IMP(label, clk, rst, cond, prop)
`define SLLT_ASSERT_NXT(label, clk, rst, cond, prop)

`endif

`endif

FILE: rtl/sllt_pkg.sv
// ----------------------------------------------------------------------------
// sllt_pkg
// shared types and constants for the sorted linked list table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sllt_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int KEY_W         = 32;
  localparam int SLOT_W        = 5;
  localparam int COUNT_W       = 6;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_DUP     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SLOT_ZERO = 2'd0,
    SLOT_CUR  = 2'd1,
    SLOT_FREE = 2'd2
  } slot_src_t;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_WALK   = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_INS_WR = 9'b000010000,
    S_INS_LK = 9'b000100000,
    S_DEL_UL = 9'b001000000,
    S_DEL_FR = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic      clr_step;
    logic      start;
    logic      step;
    logic      finish;
    logic      ins_rd;
    logic      ins_w1;
    logic      ins_w2;
    logic      del_w1;
    logic      del_w2;
    logic      set_res;
    status_t   res_status;
    slot_src_t res_slot;
    logic      out_load;
  } sllt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_go;
    logic hit;
    logic free_ok;
    logic prev_ok;
    op_t  op;
    logic out_free;
  } sllt_stat_t;

endpackage

FILE: rtl/sllt_ctrl.sv
// ----------------------------------------------------------------------------
// sllt_ctrl
// sequencer for clearing, list walk, relinking and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sllt_ctrl import sllt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sllt_stat_t stat,
  output sllt_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_go) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat.op)
          OP_SEARCH: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = stat.hit ? ST_OK : ST_MISSING;
            cmd.res_slot   = stat.hit ? SLOT_CUR : SLOT_ZERO;
            state_next     = S_DONE;
          end
          OP_INSERT: begin
            priority if (!stat.free_ok) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_FULL;
              state_next     = S_DONE;
            end else if (stat.hit) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_DUP;
              state_next     = S_DONE;
            end else begin
              cmd.ins_rd = 1'b1;
              state_next = S_INS_WR;
            end
          end
          OP_DELETE: begin
            if (stat.hit) begin
              state_next = S_DEL_UL;
            end else begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_MISSING;
              state_next     = S_DONE;
            end
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_MISSING;
            state_next     = S_DONE;
          end
        endcase
      end
      S_INS_WR: begin
        cmd.ins_w1     = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_slot   = SLOT_FREE;
        state_next     = stat.prev_ok ? S_INS_LK : S_DONE;
      end
      S_INS_LK: begin
        cmd.ins_w2 = 1'b1;
        state_next = S_DONE;
      end
      S_DEL_UL: begin
        cmd.del_w1 = 1'b1;
        state_next = S_DEL_FR;
      end
      S_DEL_FR: begin
        cmd.del_w2     = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_slot   = SLOT_CUR;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

FILE: rtl/sllt_dp.sv
// ----------------------------------------------------------------------------
// sllt_dp
// key and link memories, list pointers, walk registers and output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sllt_dp import sllt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sllt_cmd_t                cmd,
  output sllt_stat_t               stat,
  input  logic [1:0]               operation,
  input  logic signed [KEY_W-1:0]  key,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [1:0]               status,
  output logic [SLOT_W-1:0]        slot,
  output logic [COUNT_W-1:0]       entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam logic [LW-1:0] NIL  = LW'(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // memories
  logic signed [KEY_W-1:0] key_store [DEPTH];
  logic [LW-1:0]           next_link [DEPTH];
  logic signed [KEY_W-1:0] key_rd;
  logic [LW-1:0]           link_rd;

  // control registers
  logic [AW-1:0] clr;
  logic [LW-1:0] list_head;
  logic [LW-1:0] free_head;
  logic [LW-1:0] count;
  logic          out_valid_q;

  // walk and payload registers
  logic [LW-1:0]           p;
  logic [LW-1:0]           prev;
  logic [LW-1:0]           n;
  logic [AW-1:0]           cur;
  logic [LW-1:0]           cur_link;
  logic                    hit;
  op_t                     op;
  logic signed [KEY_W-1:0] key_q;
  logic [AW-1:0]           s_idx;
  status_t                 res_status;
  logic [SLOT_W-1:0]       res_slot;
  status_t                 status_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [COUNT_W-1:0]      count_q;

  logic          p_slot, n_ok, cur_valid, walk_go;
  logic          head_slot, link_slot, prev_ok, free_ok;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_idx, wr_idx;
  logic [LW-1:0] wr_data;

  assign p_slot    = (p < NIL);
  assign n_ok      = (n < NIL);
  assign cur_valid = p_slot && n_ok;
  assign walk_go   = cur_valid && (key_rd < key_q);
  assign head_slot = (list_head < NIL);
  assign link_slot = (link_rd < NIL);
  assign prev_ok   = (prev < NIL);
  assign free_ok   = (free_head < NIL);

  // read port
  always_comb begin
    rd_en  = 1'b0;
    rd_idx = '0;
    priority if (cmd.start) begin
      rd_en  = head_slot;
      rd_idx = list_head[AW-1:0];
    end else if (cmd.step) begin
      rd_en  = link_slot;
      rd_idx = link_rd[AW-1:0];
    end else if (cmd.ins_rd) begin
      rd_en  = 1'b1;
      rd_idx = free_head[AW-1:0];
    end else begin
      rd_en  = 1'b0;
    end
  end

  // link write port
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_data = '0;
    priority if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_idx  = clr;
      wr_data = (clr == LAST) ? NIL : LW'(clr) + LW'(1);
    end else if (cmd.ins_w1) begin
      wr_en   = 1'b1;
      wr_idx  = free_head[AW-1:0];
      wr_data = p;
    end else if (cmd.ins_w2) begin
      wr_en   = 1'b1;
      wr_idx  = prev[AW-1:0];
      wr_data = LW'(s_idx);
    end else if (cmd.del_w1) begin
      wr_en   = prev_ok;
      wr_idx  = prev[AW-1:0];
      wr_data = cur_link;
    end else if (cmd.del_w2) begin
      wr_en   = 1'b1;
      wr_idx  = cur;
      wr_data = free_head;
    end else begin
      wr_en   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      next_link[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      link_rd <= next_link[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_w1) begin
      key_store[free_head[AW-1:0]] <= key_q;
    end
    if (rd_en) begin
      key_rd <= key_store[rd_idx];
    end
  end

  // list pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      clr         <= '0;
      list_head   <= NIL;
      free_head   <= '0;
      count       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr <= clr + AW'(1);
      end
      if (cmd.ins_w1) begin
        free_head <= link_rd;
        count     <= count + LW'(1);
        if (!prev_ok) begin
          list_head <= LW'(free_head[AW-1:0]);
        end
      end
      if (cmd.del_w1 && !prev_ok) begin
        list_head <= cur_link;
      end
      if (cmd.del_w2) begin
        free_head <= LW'(cur);
        if (count != '0) begin
          count <= count - LW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk state and result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op    <= op_t'(operation);
      key_q <= key;
      p     <= list_head;
      prev  <= NIL;
      n     <= '0;
    end
    if (cmd.step) begin
      prev <= p;
      p    <= link_rd;
      n    <= n + LW'(1);
    end
    if (cmd.finish) begin
      cur      <= p[AW-1:0];
      cur_link <= link_rd;
      hit      <= cur_valid && (key_rd == key_q);
    end
    if (cmd.ins_w1) begin
      s_idx <= free_head[AW-1:0];
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      unique case (cmd.res_slot)
        SLOT_CUR:  res_slot <= SLOT_W'(cur);
        SLOT_FREE: res_slot <= SLOT_W'(free_head[AW-1:0]);
        default:   res_slot <= '0;
      endcase
    end
    if (cmd.out_load) begin
      status_q <= res_status;
      slot_q   <= res_slot;
      count_q  <= COUNT_W'(count);
    end
  end

  assign stat.clr_last = (clr == LAST);
  assign stat.walk_go  = walk_go;
  assign stat.hit      = hit;
  assign stat.free_ok  = free_ok;
  assign stat.prev_ok  = prev_ok;
  assign stat.op       = op;
  assign stat.out_free = !out_valid_q || out_ready;

  assign out_valid   = out_valid_q;
  assign status      = status_q;
  assign slot        = slot_q;
  assign entry_count = count_q;

endmodule

FILE: rtl/sorted_linked_list_table.sv
// ----------------------------------------------------------------------------
// sorted_linked_list_table
// ordered key table in a fixed slot pool with a free list on shared links
//
//   channel  direction  handshake              fields
//   in       input      in_valid / in_ready    operation, key
//   out      output     out_valid / out_ready  status, slot, entry_count
//
// one operation at a time: the accept cycle, then the walk along the ordered list
// with one read of the key and link memories per link followed and a step that
// closes the walk, then deciding and relinking, then loading the output register;
// the worst case is set by the link-by-link walk
// after reset a clearing pass over every slot builds the free list; no beat
// is taken meanwhile
// a new beat is accepted while the previous result still waits in the output
// register; a stalled output holds the next result back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_linked_list_table_macros.svh"

module sorted_linked_list_table import sllt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic signed [KEY_W-1:0]  key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic [SLOT_W-1:0]        slot,
  output logic [COUNT_W-1:0]       entry_count
);

  sllt_cmd_t  cmd;
  sllt_stat_t stat;

  sllt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sllt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .key         (key),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .slot        (slot),
    .entry_count (entry_count)
  );

  `SLLT_ASSERT_NXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `SLLT_ASSERT_NXT(a_result_shown, clk, rst, cmd.out_load, out_valid)
  `SLLT_ASSERT_IMP(a_alloc_free_slot, clk, rst, cmd.ins_w1, stat.free_ok)
  `SLLT_ASSERT_IMP(a_delete_on_hit, clk, rst, cmd.del_w1 || cmd.del_w2, stat.hit)

endmodule
